@@ design/tgp_pkg.sv @@
package tgp_pkg;

	localparam int CHAR_W          = 7;
	localparam int TAG_IDX_W       = 5;
	localparam int DEF_NUM_TAGS    = 23;
	localparam int DEF_MAX_STORED  = 12;
	localparam int DEF_MAX_DATA    = 16;
	localparam int DEF_MAX_TAG     = 8;
	localparam int TABLE_SIZE      = 23;

	localparam logic [CHAR_W-1:0] CH_STX = 7'h02;
	localparam logic [CHAR_W-1:0] CH_ETX = 7'h03;
	localparam logic [CHAR_W-1:0] CH_LF  = 7'h0a;
	localparam logic [CHAR_W-1:0] CH_CR  = 7'h0d;
	localparam logic [CHAR_W-1:0] CH_SP  = 7'h20;

	localparam logic [2:0] PH_OUTSIDE = 3'd0;
	localparam logic [2:0] PH_IDLE    = 3'd1;
	localparam logic [2:0] PH_TAG     = 3'd2;
	localparam logic [2:0] PH_DATA    = 3'd3;
	localparam logic [2:0] PH_CHECK   = 3'd4;
	localparam logic [2:0] PH_WAIT_CR = 3'd5;
	localparam logic [2:0] PH_DROP    = 3'd6;

	typedef struct packed {
		logic [TAG_IDX_W-1:0] tag_index;
		logic [CHAR_W-1:0]    data_char;
		logic                 char_valid;
		logic                 last;
	} res_t;

	// tag names packed 8 chars x 8 bits, last char in low bits
	function automatic logic [63:0] tag_name(input logic [5:0] i);
		logic [63:0] s;
		s = '0;
		case (i)
			6'd0:  s = 64'("ADCO");
			6'd1:  s = 64'("OPTARIF");
			6'd2:  s = 64'("ISOUSC");
			6'd3:  s = 64'("BASE");
			6'd4:  s = 64'("HCHC");
			6'd5:  s = 64'("HCHP");
			6'd6:  s = 64'("EJPHN");
			6'd7:  s = 64'("EJPHPM");
			6'd8:  s = 64'("BBRHCJB");
			6'd9:  s = 64'("BBRHPJB");
			6'd10: s = 64'("BBRHCJW");
			6'd11: s = 64'("BBRHPJW");
			6'd12: s = 64'("BBRHCJR");
			6'd13: s = 64'("BBRHPJR");
			6'd14: s = 64'("PEJP");
			6'd15: s = 64'("PTEC");
			6'd16: s = 64'("DEMAIN");
			6'd17: s = 64'("IINST");
			6'd18: s = 64'("ADPS");
			6'd19: s = 64'("IMAX");
			6'd20: s = 64'("PAPP");
			6'd21: s = 64'("HHPHC");
			6'd22: s = 64'("MOTDETAT");
			default: s = '0;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] tag_len(input logic [5:0] i);
		logic [63:0] s;
		logic [3:0]  n;
		s = tag_name(i);
		n = 4'd0;
		for (int k = 0; k < 8; k++)
			if (s[8*k +: 8] != 8'd0) n = 4'(k + 1);
		return n;
	endfunction

	// tag name re-packed to 7 bits per char, first char low
	function automatic logic [55:0] tag_chars7(input logic [5:0] i);
		logic [63:0] s;
		logic [3:0]  n;
		logic [55:0] r;
		s = tag_name(i);
		n = tag_len(i);
		r = '0;
		for (int k = 0; k < 8; k++)
			if (4'(k) < n) r[7*k +: 7] = s[8*(int'(n)-1-k) +: 7];
		return r;
	endfunction

	function automatic logic [4:0] tag_cap(input logic [5:0] i);
		logic [4:0] c;
		case (i)
			6'd0: c = 5'd12;
			6'd1: c = 5'd4;
			6'd2: c = 5'd2;
			6'd14: c = 5'd2;
			6'd15, 6'd16: c = 5'd4;
			6'd17, 6'd18, 6'd19: c = 5'd3;
			6'd20: c = 5'd5;
			6'd21: c = 5'd1;
			6'd22: c = 5'd6;
			default: c = 5'd9;
		endcase
		return c;
	endfunction

endpackage

@@ design/tgp_stream_if.sv @@
interface tgp_stream_if #(parameter int W = 7);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ design/tgp_ram.sv @@
module tgp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ design/tgp_front.sv @@
// Character parser: frame/group state, tag match and checksum.
// Data characters go to the back end's group buffer as they arrive;
// a completed good group is pushed as a tag index into a small queue.
module tgp_front import tgp_pkg::*; #(
	parameter int NUM_TAGS = DEF_NUM_TAGS,
	parameter int MAX_DATA = DEF_MAX_DATA,
	parameter int MAX_TAG  = DEF_MAX_TAG,
	localparam int DCW = $clog2(MAX_DATA + 1),
	localparam int DAW = $clog2(MAX_DATA)
) (
	input  logic              clk,
	input  logic              arst_n,
	tgp_stream_if.sink        rx,
	input  logic              q_full,
	output logic              wr_en,
	output logic [DAW-1:0]    wr_addr,
	output logic [CHAR_W-1:0] wr_char,
	output logic              push,
	output logic [5:0]        push_tag,
	output logic [DCW-1:0]    push_cnt
);
	logic [2:0]        phase_q;
	logic [55:0]       tag_q;
	logic [3:0]        tcnt_q;
	logic [DCW-1:0]    dcnt_q;
	logic [7:0]        sum_q;
	logic [CHAR_W-1:0] c;
	logic              acc;
	logic [5:0]        hit;
	logic              found;
	logic [7:0]        expect_sum;

	// while a pushed group waits in the queue the buffer must not be overwritten
	assign rx.ready = !q_full;
	assign acc = rx.valid && rx.ready;
	assign c = rx.data;
	assign expect_sum = 8'(CH_SP) + {2'b0, sum_q[5:0]};

	always_comb begin
		hit = '0;
		found = 1'b0;
		for (int i = NUM_TAGS - 1; i >= 0; i--) begin
			if (i < TABLE_SIZE && tag_len(6'(i)) == tcnt_q && tcnt_q != 0
			    && int'(tcnt_q) <= MAX_TAG && tag_chars7(6'(i)) == tag_q) begin
				hit = 6'(i);
				found = 1'b1;
			end
		end
	end

	assign wr_char = c;
	assign wr_addr = DAW'(dcnt_q);
	assign wr_en = acc && phase_q == PH_DATA && c != CH_SP && c != CH_ETX &&
		c != CH_STX && c != CH_LF && int'(dcnt_q) < MAX_DATA;
	assign push = acc && phase_q == PH_WAIT_CR && c == CH_CR && found;
	assign push_tag = hit;
	assign push_cnt = dcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OUTSIDE;
			tag_q <= '0;
			tcnt_q <= '0;
			dcnt_q <= '0;
			sum_q <= 8'h20;
		end else if (acc) begin
			if (phase_q == PH_OUTSIDE) begin
				if (c == CH_STX) phase_q <= PH_IDLE;
			end else if (c == CH_ETX) begin
				phase_q <= PH_OUTSIDE;
			end else if (c == CH_STX) begin
				phase_q <= PH_IDLE;
			end else if (c == CH_LF) begin
				tag_q <= '0;
				tcnt_q <= '0;
				dcnt_q <= '0;
				sum_q <= 8'h20;
				phase_q <= PH_TAG;
			end else begin
				case (phase_q)
					PH_TAG: begin
						if (c == CH_SP) phase_q <= PH_DATA;
						else if (int'(tcnt_q) < MAX_TAG) begin
							tag_q[7*tcnt_q[2:0] +: 7] <= c;
							tcnt_q <= tcnt_q + 4'd1;
							sum_q <= sum_q + {1'b0, c};
						end else phase_q <= PH_DROP;
					end
					PH_DATA: begin
						if (c == CH_SP) phase_q <= PH_CHECK;
						else if (int'(dcnt_q) < MAX_DATA) begin
							dcnt_q <= dcnt_q + 1'b1;
							sum_q <= sum_q + {1'b0, c};
						end else phase_q <= PH_DROP;
					end
					PH_CHECK: phase_q <= ({1'b0, c} == expect_sum) ? PH_WAIT_CR : PH_DROP;
					PH_WAIT_CR: phase_q <= PH_IDLE;
					PH_IDLE, PH_DROP: phase_q <= phase_q;
					default: phase_q <= PH_IDLE;
				endcase
			end
		end
	end
endmodule

@@ design/tgp_back.sv @@
// Group executor: compares with the stored copy, updates it, emits results.
module tgp_back import tgp_pkg::*; #(
	parameter int NUM_TAGS   = DEF_NUM_TAGS,
	parameter int MAX_STORED = DEF_MAX_STORED,
	parameter int MAX_DATA   = DEF_MAX_DATA,
	localparam int DCW = $clog2(MAX_DATA + 1),
	localparam int DAW = $clog2(MAX_DATA),
	localparam int SLW = $clog2(MAX_STORED + 1),
	localparam int SAW = $clog2(NUM_TAGS * MAX_STORED),
	localparam int TW  = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [DAW-1:0]    wr_addr,
	input  logic [CHAR_W-1:0] wr_char,
	input  logic              push,
	input  logic [5:0]        push_tag,
	input  logic [DCW-1:0]    push_cnt,
	output logic              q_full,
	tgp_stream_if.source      res
);
	localparam logic [2:0] S_IDLE = 3'd0, S_CMP = 3'd1, S_DEC = 3'd2,
		S_EMIT = 3'd3, S_WAIT = 3'd4;

	// one-entry queue of finished groups
	logic           qv_q;
	logic [5:0]     qtag_q;
	logic [DCW-1:0] qcnt_q;

	logic [2:0]       st_q;
	logic [DCW-1:0]   k_q;
	logic             diff_q;
	logic [4:0]       cap_q;
	logic [DCW-1:0]   keep_q;
	logic [NUM_TAGS-1:0] seen_q;
	logic [SLW-1:0]   slen_q [NUM_TAGS];
	logic             ov_q;
	res_t             ob_q;

	logic [CHAR_W-1:0] dbuf_rd, sv_rd;
	logic [DAW-1:0]    dbuf_ra;
	logic              sv_we;
	logic [SAW-1:0]    sv_a;
	logic              rd_pend_q;
	logic [DCW-1:0]    rk_q;
	logic [TW-1:0]     t;

	assign q_full = qv_q;
	assign t = TW'(qtag_q);

	tgp_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_DATA)) u_dbuf (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_char),
		.raddr(dbuf_ra), .rdata(dbuf_rd));

	tgp_ram #(.WIDTH(CHAR_W), .DEPTH(NUM_TAGS * MAX_STORED)) u_store (
		.clk(clk), .we(sv_we), .waddr(sv_a), .wdata(dbuf_rd),
		.raddr(sv_a), .rdata(sv_rd));

	// k indexes the read address issued this cycle; rk is the one whose data is valid
	logic issue;
	logic ob_load;
	assign dbuf_ra = DAW'(rd_pend_q ? rk_q : k_q);
	assign sv_a = SAW'(int'(t) * MAX_STORED + int'(rd_pend_q ? rk_q : k_q));
	assign sv_we = st_q == S_EMIT && rd_pend_q && (!ov_q || res.ready) && rk_q < keep_q
		&& diff_q;
	assign issue = (st_q == S_CMP) ? (!rd_pend_q && k_q < qcnt_q && 5'(k_q) < cap_q)
		: (st_q == S_EMIT && (!ov_q || res.ready) && !rd_pend_q && k_q < qcnt_q);
	// output register takes a new result this cycle
	assign ob_load = (st_q == S_DEC && diff_q && qcnt_q == '0)
		|| (st_q == S_EMIT && !issue && rd_pend_q && (!ov_q || res.ready));

	assign res.valid = ov_q;
	assign res.data = ob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_q <= 1'b0;
			st_q <= S_IDLE;
			seen_q <= '0;
			ov_q <= 1'b0;
			rd_pend_q <= 1'b0;
			k_q <= '0;
			rk_q <= '0;
			diff_q <= 1'b0;
		end else begin
			ov_q <= ob_load || (ov_q && !res.ready);
			if (push) begin
				qv_q <= 1'b1;
				qtag_q <= push_tag;
				qcnt_q <= push_cnt;
			end
			case (st_q)
				S_IDLE: if (qv_q) begin
					cap_q <= (int'(tag_cap(qtag_q)) > MAX_STORED) ?
						5'(MAX_STORED) : tag_cap(qtag_q);
					diff_q <= !seen_q[t] || DCW'(slen_q[t]) != qcnt_q;
					k_q <= '0;
					rd_pend_q <= 1'b0;
					st_q <= S_CMP;
				end
				S_CMP: begin
					rd_pend_q <= issue;
					rk_q <= k_q;
					if (issue) k_q <= k_q + 1'b1;
					if (rd_pend_q && sv_rd != dbuf_rd) diff_q <= 1'b1;
					if (!issue && !rd_pend_q) st_q <= S_DEC;
				end
				S_DEC: begin
					k_q <= '0;
					rd_pend_q <= 1'b0;
					keep_q <= (DCW'(cap_q) < qcnt_q) ? DCW'(cap_q) : qcnt_q;
					if (!diff_q) begin
						qv_q <= 1'b0;
						st_q <= S_IDLE;
					end else begin
						seen_q[t] <= 1'b1;
						slen_q[t] <= SLW'((DCW'(cap_q) < qcnt_q) ? DCW'(cap_q) : qcnt_q);
						if (qcnt_q == '0) begin
							ob_q <= '{tag_index: TAG_IDX_W'(qtag_q), data_char: '0,
								char_valid: 1'b0, last: 1'b1};
							st_q <= S_WAIT;
						end else st_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (issue) begin
						k_q <= k_q + 1'b1;
						rk_q <= k_q;
						rd_pend_q <= 1'b1;
					end else if (rd_pend_q && (!ov_q || res.ready)) begin
						ob_q <= '{tag_index: TAG_IDX_W'(qtag_q), data_char: dbuf_rd,
							char_valid: 1'b1, last: rk_q + 1'b1 == qcnt_q};
						rd_pend_q <= 1'b0;
						if (rk_q + 1'b1 == qcnt_q) st_q <= S_WAIT;
					end
				end
				S_WAIT: if (!ov_q || res.ready) begin
					qv_q <= 1'b0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ design/teleinfo_group_parser.sv @@
// Teleinfo (historic mode) group parser.
// rx: one 7-bit character per transaction. res: one transaction per data
// character of a published group (tag_index, data_char, char_valid, last);
// empty data gives a single transaction with char_valid low.
// A front parser tracks STX/ETX frames and LF..CR groups, writing data
// characters into a group buffer and checking tag and checksum at speed:
// one character per cycle unless rx is stalled. A good group is handed to
// the back end through a one-entry queue; rx stalls only while that entry
// is occupied. The back end compares the group with the stored copy,
// reading one character and comparing it before it reads the next (one
// port on the store RAM), then emits the characters in the same way while
// res is ready, and writes the truncated copy back.
// Reset returns the parser outside a frame and forgets every seen tag;
// stored copies only count in the comparison after their tag was published once.
// When res stalls the held result stays put and the back end waits;
// rx stays stalled until the back end has finished the group.
module teleinfo_group_parser import tgp_pkg::*; #(
	parameter int NUM_TAGS       = DEF_NUM_TAGS,
	parameter int MAX_STORED_LEN = DEF_MAX_STORED,
	parameter int MAX_DATA_LEN   = DEF_MAX_DATA,
	parameter int MAX_TAG_LEN    = DEF_MAX_TAG,
	localparam int DCW = $clog2(MAX_DATA_LEN + 1),
	localparam int DAW = $clog2(MAX_DATA_LEN)
) (
	input  logic         clk,
	input  logic         arst_n,
	tgp_stream_if.sink   rx,
	tgp_stream_if.source res
);
	logic              q_full, wr_en, push;
	logic [DAW-1:0]    wr_addr;
	logic [CHAR_W-1:0] wr_char;
	logic [5:0]        push_tag;
	logic [DCW-1:0]    push_cnt;

	tgp_front #(.NUM_TAGS(NUM_TAGS), .MAX_DATA(MAX_DATA_LEN), .MAX_TAG(MAX_TAG_LEN))
	u_front (
		.clk(clk), .arst_n(arst_n), .rx(rx), .q_full(q_full), .wr_en(wr_en),
		.wr_addr(wr_addr), .wr_char(wr_char), .push(push), .push_tag(push_tag),
		.push_cnt(push_cnt));

	tgp_back #(.NUM_TAGS(NUM_TAGS), .MAX_STORED(MAX_STORED_LEN), .MAX_DATA(MAX_DATA_LEN))
	u_back (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_addr(wr_addr),
		.wr_char(wr_char), .push(push), .push_tag(push_tag), .push_cnt(push_cnt),
		.q_full(q_full), .res(res));

	// a group is never pushed while the queue entry is taken
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_full)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) q_full |-> !rx.ready)
		else $error("rx ready while queue full");
	assert property (@(posedge clk) disable iff (!arst_n) push |=> q_full)
		else $error("pushed group lost");
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import tgp_pkg::*;

	typedef enum logic [2:0] {
		P_OUT, P_IDLE, P_TAG, P_DATA, P_CHECK, P_WAIT_CR, P_DROP
	} phase_e;

	localparam int N_TAGS   = 23;
	localparam int STORE_W  = 12;
	localparam int DATA_MAX = 16;
	localparam int TAG_MAX  = 8;
	localparam int N_ITEMS  = 410;

	// tag list and stored widths for the local prediction
	string    tag_list[N_TAGS] = '{
		"ADCO", "OPTARIF", "ISOUSC", "BASE", "HCHC", "HCHP", "EJPHN", "EJPHPM",
		"BBRHCJB", "BBRHPJB", "BBRHCJW", "BBRHPJW", "BBRHCJR", "BBRHPJR",
		"PEJP", "PTEC", "DEMAIN", "IINST", "ADPS", "IMAX", "PAPP", "HHPHC",
		"MOTDETAT"};
	int       store_cap[N_TAGS] = '{12, 4, 2, 9, 9, 9, 9, 9, 9, 9, 9, 9, 9, 9,
		2, 4, 4, 3, 3, 3, 5, 1, 6};

	logic clk;
	logic arst_n;

	tgp_stream_if #(.W(CHAR_W))       rx_if ();
	tgp_stream_if #(.W($bits(res_t))) res_if ();

	teleinfo_group_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if.sink),
		.res    (res_if.source)
	);

	// characters waiting to be sent, and published characters still awaited
	logic [6:0] char_queue[$];
	res_t       publish_queue[$];

	// parser state mirror
	phase_e     ph;
	logic [6:0] cur_tag[TAG_MAX];
	int         cur_tag_n;
	logic [6:0] cur_data[DATA_MAX];
	int         cur_data_n;
	logic [7:0] cur_sum;
	logic [6:0] kept_val[N_TAGS][STORE_W];
	int         kept_len[N_TAGS];
	bit         tag_known[N_TAGS];

	// last data sent per tag, so random groups can repeat values
	string      last_sent[N_TAGS];

	int n_groups_out, n_chars_out, n_mismatch;
	bit taken;
	int gap_left, burst_left, stall_mode, stall_cnt;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Prediction: one character in, any published characters queued.
	// ---------------------------------------------------------------
	function automatic int match_tag();
		int i, k;
		bit same;
		for (i = 0; i < N_TAGS; i++) begin
			if (tag_list[i].len() != cur_tag_n || cur_tag_n == 0)
				continue;
			same = 1;
			for (k = 0; k < cur_tag_n; k++)
				if (cur_tag[k] != 7'(tag_list[i][k])) same = 0;
			if (same) return i;
		end
		return -1;
	endfunction

	task automatic close_group();
		int   idx, cap, keep, k;
		bit   fresh;
		res_t r;
		idx = match_tag();
		if (idx < 0) return;
		cap   = store_cap[idx];
		fresh = !tag_known[idx] || kept_len[idx] != cur_data_n;
		for (k = 0; !fresh && k < cur_data_n && k < cap; k++)
			if (kept_val[idx][k] != cur_data[k]) fresh = 1;
		if (!fresh) return;
		keep = cur_data_n < cap ? cur_data_n : cap;
		for (k = 0; k < keep; k++) kept_val[idx][k] = cur_data[k];
		kept_len[idx]  = keep;
		tag_known[idx] = 1;
		n_groups_out++;
		if (cur_data_n == 0) begin
			r = '{tag_index: 5'(idx), data_char: '0, char_valid: 1'b0, last: 1'b1};
			publish_queue.push_back(r);
			return;
		end
		for (k = 0; k < cur_data_n; k++) begin
			r = '{tag_index: 5'(idx), data_char: cur_data[k], char_valid: 1'b1,
				last: (k + 1 == cur_data_n)};
			publish_queue.push_back(r);
		end
	endtask

	task automatic parse_char(input logic [6:0] c);
		if (ph == P_OUT) begin
			if (c == CH_STX) ph = P_IDLE;
			return;
		end
		if (c == CH_ETX) begin ph = P_OUT; return; end
		if (c == CH_STX) begin ph = P_IDLE; return; end
		if (c == CH_LF) begin
			cur_tag_n  = 0;
			cur_data_n = 0;
			cur_sum    = 8'h20;
			ph         = P_TAG;
			return;
		end
		case (ph)
			P_TAG: begin
				if (c == CH_SP) ph = P_DATA;
				else if (cur_tag_n < TAG_MAX) begin
					cur_tag[cur_tag_n] = c;
					cur_tag_n++;
					cur_sum += 8'(c);
				end else ph = P_DROP;
			end
			P_DATA: begin
				if (c == CH_SP) ph = P_CHECK;
				else if (cur_data_n < DATA_MAX) begin
					cur_data[cur_data_n] = c;
					cur_data_n++;
					cur_sum += 8'(c);
				end else ph = P_DROP;
			end
			P_CHECK: ph = (c == 7'(8'h20 + (cur_sum & 8'h3f))) ? P_WAIT_CR : P_DROP;
			P_WAIT_CR: begin
				ph = P_IDLE;
				if (c == CH_CR) close_group();
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------
	// Stimulus building
	// ---------------------------------------------------------------
	// flaw: 0 good, 1 bad checksum, 2 no CR, 3 cut short before the checksum
	task automatic queue_group(input string tag, input string val, input int flaw);
		logic [7:0] s;
		int k;
		s = 8'h20;
		char_queue.push_back(CH_LF);
		for (k = 0; k < tag.len(); k++) begin
			char_queue.push_back(7'(tag[k]));
			s += 8'(tag[k]);
		end
		char_queue.push_back(CH_SP);
		for (k = 0; k < val.len(); k++) begin
			char_queue.push_back(7'(val[k]));
			s += 8'(val[k]);
		end
		if (flaw == 3) return;
		char_queue.push_back(CH_SP);
		s = 8'h20 + (s & 8'h3f);
		if (flaw == 1)
			s = 8'h20 + ((s - 8'h20 + 8'(1 + $urandom_range(0, 62))) & 8'h3f);
		char_queue.push_back(7'(s));
		char_queue.push_back(flaw == 2 ? 7'(CH_CR + 1) : CH_CR);
	endtask

	function automatic string rand_value(input int n);
		string v;
		int k;
		v = "";
		for (k = 0; k < n; k++)
			v = {v, string'(8'($urandom_range(8'h21, 8'h7e)))};
		return v;
	endfunction

	task automatic build_random();
		int    pick, idx, n, flaw;
		string v;
		while (char_queue.size() < N_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				idx = $urandom_range(0, N_TAGS - 1);
				if (last_sent[idx] != "" && $urandom_range(0, 2) == 0) v = last_sent[idx];
				else begin
					n = $urandom_range(0, 3) == 0 ? $urandom_range(0, DATA_MAX + 1)
						: $urandom_range(1, store_cap[idx] + 1);
					v = rand_value(n);
				end
				flaw = $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : 0;
				if (flaw == 0) last_sent[idx] = v;
				queue_group(tag_list[idx], v, flaw);
			end else if (pick < 80) begin
				queue_group(rand_value($urandom_range(0, 9)), rand_value(2), 0);
			end else if (pick < 92) begin
				char_queue.push_back(7'($urandom_range(0, 127)));
			end else begin
				// leave the frame, some ignored noise, re-enter
				char_queue.push_back(CH_ETX);
				repeat ($urandom_range(0, 3)) char_queue.push_back(7'($urandom_range(0, 127)));
				char_queue.push_back(CH_STX);
			end
		end
		char_queue.push_back(CH_ETX);
	endtask

	// ---------------------------------------------------------------
	// Driver: bursts of transactions with random gaps
	// ---------------------------------------------------------------
	always @(posedge clk)
		if (rx_if.valid && rx_if.ready) begin
			parse_char(rx_if.data);
			taken <= 1'b1;
		end

	always @(negedge clk) begin
		if (arst_n && !(rx_if.valid && !taken)) begin
			taken <= 1'b0;
			if (gap_left > 0 || char_queue.size() == 0) begin
				rx_if.valid <= 1'b0;
				if (gap_left > 0) gap_left <= gap_left - 1;
			end else begin
				rx_if.valid <= 1'b1;
				rx_if.data  <= char_queue.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
				end else burst_left <= burst_left - 1;
			end
		end
	end

	// receiver stall pattern: a random mode is picked each time stall_cnt wraps
	always @(negedge clk) begin
		if (stall_cnt == 0) stall_mode <= $urandom_range(0, 2);
		stall_cnt <= (stall_cnt + 1) % 64;
		case (stall_mode)
			0: res_if.ready <= 1'b1;
			1: res_if.ready <= $urandom_range(0, 1);
			default: res_if.ready <= $urandom_range(0, 3) == 0;
		endcase
	end

	// ---------------------------------------------------------------
	// Monitor
	// ---------------------------------------------------------------
	always @(posedge clk)
		if (arst_n && res_if.valid && res_if.ready) begin
			res_t got, want;
			got = res_t'(res_if.data);
			if (publish_queue.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected transaction %h", got);
			end else begin
				want = publish_queue.pop_front();
				n_chars_out++;
				if (got !== want) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch: tag %0d/%0d char %h/%h valid %b/%b last %b/%b",
							want.tag_index, got.tag_index, want.data_char, got.data_char,
							want.char_valid, got.char_valid, want.last, got.last);
				end
			end
		end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	initial begin
		int i;
		ph = P_OUT;
		cur_tag_n = 0; cur_data_n = 0; cur_sum = 8'h20;
		for (i = 0; i < N_TAGS; i++) begin tag_known[i] = 0; kept_len[i] = 0; end
		n_groups_out = 0; n_chars_out = 0; n_mismatch = 0;
		taken = 0; gap_left = 0; burst_left = 1; stall_mode = 0; stall_cnt = 0;
		rx_if.valid = 1'b0;
		rx_if.data  = '0;
		res_if.ready = 1'b0;
		arst_n = 1'b0;

		// directed: ignored extremes outside a frame, full 12-char value,
		// unchanged repeat, empty data, over-long tag, then frame end
		char_queue.push_back(7'h00);
		char_queue.push_back(7'h7f);
		char_queue.push_back(CH_STX);
		queue_group("ADCO", "0123456789~\x7f", 0);
		queue_group("ADCO", "0123456789~\x7f", 0);
		queue_group("HHPHC", "", 0);
		queue_group("BBRHCJBXY", "1", 0);
		char_queue.push_back(CH_ETX);
		build_random();

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (char_queue.size() == 0 && !rx_if.valid && publish_queue.size() == 0);
		repeat (200) @(posedge clk);
		$display("sent characters: framed groups, noise, bad checksums, missing CRs,");
		$display("cut groups; %0d groups published as %0d transactions",
			n_groups_out, n_chars_out);
		if (n_mismatch == 0 && publish_queue.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ teleinfo_group_parser.f @@
design/tgp_pkg.sv
design/tgp_stream_if.sv
design/tgp_ram.sv
design/tgp_front.sv
design/tgp_back.sv
design/teleinfo_group_parser.sv
tb/testbench.sv
